// ===== hdl/fdm_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fdm_pkg
// Shared constants, types and the gaussian gain table of the mask filter.
// ---------------------------------------------------------------------------
package fdm_pkg;

    localparam int MAX_DIM    = 1024;
    localparam int DIM_W      = 11;
    localparam int POS_W      = 10;
    localparam int OFF_W      = 11;
    localparam int SQ_W       = 22;
    localparam int D2_W       = 20;
    localparam int SAMPLE_W   = 32;
    localparam int OUT_W      = 52;
    localparam int GAIN_W     = 17;
    localparam int EXP_DEPTH  = 256;
    localparam int EXP_RANGE  = 16;
    localparam int IDX_W      = 8;
    localparam int NUM_W      = D2_W + 3;
    localparam int LIM_W      = SQ_W + 5;
    localparam int DIVW       = SQ_W + IDX_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;
    localparam int MODE_W     = 3;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

    localparam logic [MODE_W-1:0] MODE_PASS  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDEAL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GLP   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GHP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LAP   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 8'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DIM_W-1:0]  shape_arg;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic              lap;
        logic [GAIN_W-1:0] gain;
        logic [D2_W-1:0]   d2;
    } gain_ctrl_t;

    typedef logic [GAIN_W-1:0] exp_tab_t [EXP_DEPTH];

    function automatic longint unsigned udiv_q(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic exp_tab_t build_exp_table();
        exp_tab_t          tab;
        longint unsigned   q30_one;
        longint unsigned   term;
        longint unsigned   pos;
        longint unsigned   neg;
        longint unsigned   e1;
        longint unsigned   num;
        longint unsigned   n;
        longint unsigned   r;
        longint unsigned   v;
        q30_one = 64'd1 << 30;
        term = q30_one;
        pos = q30_one;
        neg = 0;
        for (int i = 1; i <= 24; i++)
        begin
            term = udiv_q(term, longint'(i));
            if ((i % 2) == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        e1 = pos - neg;
        for (int k = 0; k < EXP_DEPTH; k++)
        begin
            num = longint'(EXP_RANGE) * longint'(k);
            n = num / EXP_DEPTH;
            r = num % EXP_DEPTH;
            term = q30_one;
            pos = q30_one;
            neg = 0;
            for (int i = 1; i <= 24; i++)
            begin
                term = udiv_q(term * r, longint'(EXP_DEPTH) * longint'(i));
                if ((i % 2) == 1)
                    neg = neg + term;
                else
                    pos = pos + term;
            end
            v = pos - neg;
            for (longint unsigned j = 0; j < n; j++)
            begin
                v = (v * e1 + (q30_one >> 1)) >> 30;
            end
            tab[k] = GAIN_W'((v + (64'd1 << 13)) >> 14);
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage
`default_nettype wire

// ===== hdl/fdm_offset.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fdm_offset
// Three-stage centered offset of row and column, reduced modulo the size.
// ---------------------------------------------------------------------------
module fdm_offset (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [fdm_pkg::POS_W-1:0]    row,
    input  wire logic [fdm_pkg::POS_W-1:0]    col,
    input  wire fdm_pkg::cfg_t                cfg,
    output logic                              out_valid,
    output logic signed [fdm_pkg::OFF_W-1:0]  dy,
    output logic signed [fdm_pkg::OFF_W-1:0]  dx
);

    logic [fdm_pkg::DIM_W-1:0] size_eff [2];
    logic [fdm_pkg::DIM_W-1:0] half [2];
    logic [fdm_pkg::DIM_W-1:0] rem1_reg [2];
    logic [fdm_pkg::DIM_W-1:0] rem1_next [2];
    logic [fdm_pkg::DIM_W-1:0] rem2_reg [2];
    logic [fdm_pkg::DIM_W-1:0] rem2_next [2];
    logic signed [fdm_pkg::OFF_W-1:0] off_reg [2];
    logic signed [fdm_pkg::OFF_W-1:0] off_next [2];
    logic [2:0] valid_reg;

    function automatic logic [fdm_pkg::DIM_W-1:0] reduce_step(
        input logic [fdm_pkg::DIM_W-1:0] rem,
        input logic [fdm_pkg::DIM_W-1:0] s,
        input int                        k
    );
        logic [2*fdm_pkg::DIM_W-1:0] sub;
        sub = (2*fdm_pkg::DIM_W)'(s) << k;
        if ((2*fdm_pkg::DIM_W)'(rem) >= sub)
            return rem - fdm_pkg::DIM_W'(sub);
        return rem;
    endfunction

    always_comb
    begin
        logic [fdm_pkg::DIM_W-1:0] sz;
        logic [fdm_pkg::DIM_W-1:0] t1;
        logic [fdm_pkg::DIM_W-1:0] t2;
        logic [fdm_pkg::DIM_W-1:0] t3;
        for (int a = 0; a < 2; a++)
        begin
            sz = (a == 0) ? cfg.image_height : cfg.image_width;
            if (sz == '0)
                size_eff[a] = fdm_pkg::DIM_W'(1);
            else if (sz > fdm_pkg::DIM_W'(fdm_pkg::MAX_DIM))
                size_eff[a] = fdm_pkg::DIM_W'(fdm_pkg::MAX_DIM);
            else
                size_eff[a] = sz;
            half[a] = size_eff[a] >> 1;
            t1 = ((a == 0) ? fdm_pkg::DIM_W'(row) : fdm_pkg::DIM_W'(col)) + half[a];
            for (int k = 10; k >= 7; k--)
            begin
                t1 = reduce_step(t1, size_eff[a], k);
            end
            rem1_next[a] = t1;
            t2 = rem1_reg[a];
            for (int k = 6; k >= 3; k--)
            begin
                t2 = reduce_step(t2, size_eff[a], k);
            end
            rem2_next[a] = t2;
            t3 = rem2_reg[a];
            for (int k = 2; k >= 0; k--)
            begin
                t3 = reduce_step(t3, size_eff[a], k);
            end
            off_next[a] = $signed(t3 - half[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        rem1_reg <= rem1_next;
        rem2_reg <= rem2_next;
        off_reg  <= off_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    assign out_valid = valid_reg[2];
    assign dy = off_reg[0];
    assign dx = off_reg[1];

endmodule
`default_nettype wire

// ===== hdl/fdm_gain.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fdm_gain
// Seven-stage gain path: squared radius, table index division, mode gain.
// ---------------------------------------------------------------------------
module fdm_gain (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic signed [fdm_pkg::OFF_W-1:0] dy,
    input  wire logic signed [fdm_pkg::OFF_W-1:0] dx,
    input  wire fdm_pkg::cfg_t                cfg,
    output fdm_pkg::gain_ctrl_t               ctrl
);

    localparam int DIV_STAGES = 4;

    logic [fdm_pkg::SQ_W-1:0]  s2_reg;
    logic [fdm_pkg::SQ_W-1:0]  c2_reg;
    logic [fdm_pkg::LIM_W-1:0] lim_reg;
    logic [fdm_pkg::DIM_W-1:0] s_eff;

    logic [fdm_pkg::D2_W-1:0]  sqy_reg;
    logic [fdm_pkg::D2_W-1:0]  sqx_reg;
    logic signed [2*fdm_pkg::OFF_W-1:0] sqy_full;
    logic signed [2*fdm_pkg::OFF_W-1:0] sqx_full;

    logic [fdm_pkg::D2_W-1:0]  d2_reg [DIV_STAGES+1];
    logic                      ideal_reg [DIV_STAGES+1];
    logic                      over_reg [DIV_STAGES+1];
    logic [fdm_pkg::NUM_W-1:0] rem_reg [DIV_STAGES+1];
    logic [fdm_pkg::NUM_W-1:0] rem_next [DIV_STAGES];
    logic [fdm_pkg::IDX_W-1:0] quo_reg [DIV_STAGES+1];
    logic [fdm_pkg::IDX_W-1:0] quo_next [DIV_STAGES];
    logic [fdm_pkg::D2_W-1:0]  d2_sum;
    logic [DIV_STAGES+1:0]     valid_reg;

    logic [fdm_pkg::GAIN_W-1:0] lp;
    logic [fdm_pkg::GAIN_W-1:0] gain_next;
    logic                       valid_out_reg;
    logic                       lap_reg;
    logic [fdm_pkg::GAIN_W-1:0] gain_reg;
    logic [fdm_pkg::D2_W-1:0]   d2_out_reg;

    assign s_eff = (cfg.shape_arg == '0) ? fdm_pkg::DIM_W'(1) : cfg.shape_arg;

    always_ff @(posedge clk)
    begin
        s2_reg  <= fdm_pkg::SQ_W'(s_eff) * fdm_pkg::SQ_W'(s_eff);
        c2_reg  <= fdm_pkg::SQ_W'(cfg.shape_arg) * fdm_pkg::SQ_W'(cfg.shape_arg);
        lim_reg <= fdm_pkg::LIM_W'(fdm_pkg::SQ_W'(s_eff) * fdm_pkg::SQ_W'(s_eff)) << 5;
    end

    assign sqy_full = fdm_pkg::SQ_W'(dy) * fdm_pkg::SQ_W'(dy);
    assign sqx_full = fdm_pkg::SQ_W'(dx) * fdm_pkg::SQ_W'(dx);
    assign d2_sum = sqy_reg + sqx_reg;

    always_comb
    begin
        logic [fdm_pkg::DIVW-1:0] sub;
        logic [fdm_pkg::NUM_W-1:0] r;
        logic [fdm_pkg::IDX_W-1:0] q;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            r = rem_reg[j];
            q = quo_reg[j];
            for (int b = 7 - 2*j; b >= 6 - 2*j; b--)
            begin
                sub = fdm_pkg::DIVW'(s2_reg) << b;
                if (fdm_pkg::DIVW'(r) >= sub)
                begin
                    r = r - fdm_pkg::NUM_W'(sub);
                    q[b] = 1'b1;
                end
            end
            rem_next[j] = r;
            quo_next[j] = q;
        end
    end

    always_comb
    begin
        lp = over_reg[DIV_STAGES] ? '0 : fdm_pkg::EXP_TABLE[quo_reg[DIV_STAGES]];
        unique case (cfg.mode)
            fdm_pkg::MODE_IDEAL: gain_next = ideal_reg[DIV_STAGES] ? fdm_pkg::GAIN_ONE : '0;
            fdm_pkg::MODE_GLP:   gain_next = lp;
            fdm_pkg::MODE_GHP:   gain_next = fdm_pkg::GAIN_ONE - lp;
            default:             gain_next = fdm_pkg::GAIN_ONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        sqy_reg <= fdm_pkg::D2_W'(sqy_full);
        sqx_reg <= fdm_pkg::D2_W'(sqx_full);
        d2_reg[0]    <= d2_sum;
        ideal_reg[0] <= fdm_pkg::SQ_W'(d2_sum) <= c2_reg;
        over_reg[0]  <= fdm_pkg::LIM_W'(d2_sum) >= lim_reg;
        rem_reg[0]   <= {d2_sum, 3'b000};
        quo_reg[0]   <= '0;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            d2_reg[j+1]    <= d2_reg[j];
            ideal_reg[j+1] <= ideal_reg[j];
            over_reg[j+1]  <= over_reg[j];
            rem_reg[j+1]   <= rem_next[j];
            quo_reg[j+1]   <= quo_next[j];
        end
        lap_reg    <= (cfg.mode == fdm_pkg::MODE_LAP);
        gain_reg   <= gain_next;
        d2_out_reg <= d2_reg[DIV_STAGES];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            valid_out_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[DIV_STAGES:0], in_valid};
            valid_out_reg <= valid_reg[DIV_STAGES+1];
        end
    end

    assign ctrl = '{valid: valid_out_reg, lap: lap_reg, gain: gain_reg, d2: d2_out_reg};

endmodule
`default_nettype wire

// ===== hdl/fdm_scale.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fdm_scale
// Three-stage scaling of both sample parts: magnitude, product, rounding
// or saturation.
// ---------------------------------------------------------------------------
module fdm_scale (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire fdm_pkg::gain_ctrl_t                 ctrl,
    input  wire logic signed [fdm_pkg::SAMPLE_W-1:0] re_in,
    input  wire logic signed [fdm_pkg::SAMPLE_W-1:0] im_in,
    output logic                                     out_valid,
    output logic signed [fdm_pkg::OUT_W-1:0]         re_out,
    output logic signed [fdm_pkg::OUT_W-1:0]         im_out,
    output logic                                     sat
);

    logic [fdm_pkg::SAMPLE_W-1:0] mag_reg [2];
    logic                         neg1_reg [2];
    logic                         neg2_reg [2];
    logic [fdm_pkg::D2_W-1:0]     op_reg;
    logic                         lap1_reg;
    logic                         lap2_reg;
    logic [fdm_pkg::OUT_W-1:0]    prod_reg [2];
    logic [fdm_pkg::OUT_W-1:0]    res_reg [2];
    logic [fdm_pkg::OUT_W-1:0]    res_next [2];
    logic                         clip_next [2];
    logic                         sat_reg;
    logic [2:0]                   valid_reg;
    logic signed [fdm_pkg::SAMPLE_W-1:0] raw [2];

    assign raw[0] = re_in;
    assign raw[1] = im_in;

    always_comb
    begin
        logic                      rneg;
        logic [fdm_pkg::OUT_W-1:0] cap;
        logic [fdm_pkg::OUT_W-1:0] mag;
        for (int p = 0; p < 2; p++)
        begin
            rneg = !neg2_reg[p];
            cap = (fdm_pkg::OUT_W'(1) << (fdm_pkg::OUT_W - 1))
                  - (rneg ? fdm_pkg::OUT_W'(0) : fdm_pkg::OUT_W'(1));
            if (lap2_reg)
            begin
                clip_next[p] = prod_reg[p] > cap;
                mag = clip_next[p] ? cap : prod_reg[p];
                res_next[p] = rneg ? -mag : mag;
            end
            else
            begin
                clip_next[p] = 1'b0;
                mag = (prod_reg[p] + fdm_pkg::OUT_W'(32768)) >> 16;
                res_next[p] = neg2_reg[p] ? -mag : mag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < 2; p++)
        begin
            neg1_reg[p] <= raw[p][fdm_pkg::SAMPLE_W-1];
            mag_reg[p]  <= raw[p][fdm_pkg::SAMPLE_W-1] ? fdm_pkg::SAMPLE_W'(-raw[p])
                                                         : fdm_pkg::SAMPLE_W'(raw[p]);
            neg2_reg[p] <= neg1_reg[p];
            prod_reg[p] <= fdm_pkg::OUT_W'(mag_reg[p]) * fdm_pkg::OUT_W'(op_reg);
            res_reg[p]  <= res_next[p];
        end
        op_reg   <= ctrl.lap ? ctrl.d2 : fdm_pkg::D2_W'(ctrl.gain);
        lap1_reg <= ctrl.lap;
        lap2_reg <= lap1_reg;
        sat_reg  <= clip_next[0] | clip_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], ctrl.valid};
    end

    assign out_valid = valid_reg[2];
    assign re_out = $signed(res_reg[0]);
    assign im_out = $signed(res_reg[1]);
    assign sat = sat_reg;

endmodule
`default_nettype wire

// ===== hdl/freq_domain_mask_filter_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// freq_domain_mask_filter_top
// Frequency-domain mask filter: centered radius, mode gain, scaled sample.
// ---------------------------------------------------------------------------
//  channel   handshake               payload
//  request   start, busy             row, col, real_in, imag_in
//  result    done (one-cycle strobe) real_out, imag_out, saturated
//  config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// One request enters every cycle; busy stays low. Each result appears as a
// done strobe after its request has passed the offset (3), gain (7) and
// scale (3) pipeline stages. Reset clears the valid bits and the
// registers to mode 0, shape 0 and a 1024 by 1024 spectrum.
module freq_domain_mask_filter_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [fdm_pkg::POS_W-1:0]            row,
    input  wire logic [fdm_pkg::POS_W-1:0]            col,
    input  wire logic signed [fdm_pkg::SAMPLE_W-1:0]  real_in,
    input  wire logic signed [fdm_pkg::SAMPLE_W-1:0]  imag_in,
    output logic                                      done,
    output logic signed [fdm_pkg::OUT_W-1:0]          real_out,
    output logic signed [fdm_pkg::OUT_W-1:0]          imag_out,
    output logic                                      saturated,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [fdm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fdm_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int DELAY = 10;

    fdm_pkg::cfg_t cfg_reg;
    logic signed [fdm_pkg::SAMPLE_W-1:0] re_dly_reg [DELAY];
    logic signed [fdm_pkg::SAMPLE_W-1:0] im_dly_reg [DELAY];
    logic                                 accept;
    logic                                 off_valid;
    logic signed [fdm_pkg::OFF_W-1:0]     dy;
    logic signed [fdm_pkg::OFF_W-1:0]     dx;
    fdm_pkg::gain_ctrl_t                  ctrl;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= fdm_pkg::MODE_PASS;
            cfg_reg.shape_arg    <= '0;
            cfg_reg.image_width  <= fdm_pkg::DIM_W'(fdm_pkg::MAX_DIM);
            cfg_reg.image_height <= fdm_pkg::DIM_W'(fdm_pkg::MAX_DIM);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fdm_pkg::REG_MODE:   cfg_reg.mode <= cfg_data[fdm_pkg::MODE_W-1:0];
                fdm_pkg::REG_SHAPE:  cfg_reg.shape_arg <= cfg_data;
                fdm_pkg::REG_WIDTH:  cfg_reg.image_width <= cfg_data;
                fdm_pkg::REG_HEIGHT: cfg_reg.image_height <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        re_dly_reg[0] <= real_in;
        im_dly_reg[0] <= imag_in;
        for (int k = 1; k < DELAY; k++)
        begin
            re_dly_reg[k] <= re_dly_reg[k-1];
            im_dly_reg[k] <= im_dly_reg[k-1];
        end
    end

    fdm_offset u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .row       (row),
        .col       (col),
        .cfg       (cfg_reg),
        .out_valid (off_valid),
        .dy        (dy),
        .dx        (dx)
    );

    fdm_gain u_gain (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (off_valid),
        .dy       (dy),
        .dx       (dx),
        .cfg      (cfg_reg),
        .ctrl     (ctrl)
    );

    fdm_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .re_in     (re_dly_reg[DELAY-1]),
        .im_in     (im_dly_reg[DELAY-1]),
        .out_valid (done),
        .re_out    (real_out),
        .im_out    (imag_out),
        .sat       (saturated)
    );

endmodule
`default_nettype wire

// ===== sim/mask_filter_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mask_filter_checker
// Watches the request, result and register channels of the mask filter. It
// keeps its own copy of the registers, predicts the filtered sample for each
// accepted request and compares each done strobe with the oldest prediction.
// ---------------------------------------------------------------------------
module mask_filter_checker
    import fdm_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic [POS_W-1:0]            row,
    input  wire logic [POS_W-1:0]            col,
    input  wire logic signed [SAMPLE_W-1:0]  real_in,
    input  wire logic signed [SAMPLE_W-1:0]  imag_in,
    input  wire logic                        done,
    input  wire logic signed [OUT_W-1:0]     real_out,
    input  wire logic signed [OUT_W-1:0]     imag_out,
    input  wire logic                        saturated,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       cfg_data,
    output int                               errors,
    output int                               pending
);

    typedef struct {
        logic [OUT_W-1:0] re;
        logic [OUT_W-1:0] im;
        logic             sat;
    } filtered_t;

    filtered_t           filtered_q[$];
    logic [MODE_W-1:0]   cur_mode;
    logic [DIM_W-1:0]    cur_shape;
    logic [DIM_W-1:0]    cur_width;
    logic [DIM_W-1:0]    cur_height;
    longint unsigned     gauss_q16[EXP_DEPTH];

    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    function automatic longint unsigned neg_exp_q30(longint unsigned num, longint unsigned den);
        longint unsigned t;
        longint unsigned plus;
        longint unsigned minus;
        t = ONE_Q30;
        plus = ONE_Q30;
        minus = 0;
        for (int i = 1; i <= 24; i++)
        begin
            t = t * num / (den * longint'(i));
            if (i % 2 == 1)
                minus += t;
            else
                plus += t;
        end
        return plus - minus;
    endfunction

    initial
    begin
        longint unsigned e_inv;
        longint unsigned v;
        e_inv = neg_exp_q30(1, 1);
        for (int k = 0; k < EXP_DEPTH; k++)
        begin
            v = neg_exp_q30((EXP_RANGE * k) % EXP_DEPTH, EXP_DEPTH);
            for (int j = 0; j < (EXP_RANGE * k) / EXP_DEPTH; j++)
                v = (v * e_inv + (ONE_Q30 >> 1)) >> 30;
            gauss_q16[k] = (v + (64'd1 << 13)) >> 14;
        end
    end

    function automatic longint centered_offset(logic [POS_W-1:0] p, logic [DIM_W-1:0] size);
        longint s;
        longint half;
        s = size;
        if (s < 1)
            s = 1;
        if (s > MAX_DIM)
            s = MAX_DIM;
        half = s / 2;
        return ((longint'(p) + half) % s) - half;
    endfunction

    function automatic logic [OUT_W-1:0] apply_gain(logic signed [SAMPLE_W-1:0] x,
                                                    longint unsigned g);
        longint unsigned mag;
        longint unsigned r;
        mag = (x < 0) ? longint'(-longint'(x)) : longint'(x);
        r = (mag * g + (64'd1 << 15)) >> 16;
        return (x < 0) ? OUT_W'(-r) : OUT_W'(r);
    endfunction

    function automatic logic [OUT_W-1:0] apply_laplacian(logic signed [SAMPLE_W-1:0] x,
                                                         longint unsigned d2,
                                                         inout logic clipped);
        longint unsigned mag;
        longint unsigned cap;
        logic            res_neg;
        mag = (x < 0) ? longint'(-longint'(x)) : longint'(x);
        res_neg = !(x < 0);
        cap = (64'd1 << (OUT_W - 1)) - (res_neg ? 0 : 1);
        if (d2 != 0 && mag > cap / d2)
        begin
            clipped = 1'b1;
            return res_neg ? OUT_W'(-cap) : OUT_W'(cap);
        end
        return res_neg ? OUT_W'(-(mag * d2)) : OUT_W'(mag * d2);
    endfunction

    function automatic filtered_t filter_sample(logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                                               logic signed [SAMPLE_W-1:0] re,
                                               logic signed [SAMPLE_W-1:0] im);
        filtered_t       f;
        longint          dy;
        longint          dx;
        longint unsigned d2;
        longint unsigned sig;
        longint unsigned idx;
        longint unsigned lp;
        longint unsigned g;
        dy = centered_offset(r, cur_height);
        dx = centered_offset(c, cur_width);
        d2 = dy * dy + dx * dx;
        f.sat = 1'b0;
        if (cur_mode == MODE_LAP)
        begin
            f.re = apply_laplacian(re, d2, f.sat);
            f.im = apply_laplacian(im, d2, f.sat);
            return f;
        end
        g = 65536;
        if (cur_mode == MODE_IDEAL)
            g = (d2 <= longint'(cur_shape) * cur_shape) ? 65536 : 0;
        else if (cur_mode == MODE_GLP || cur_mode == MODE_GHP)
        begin
            sig = (cur_shape == 0) ? 1 : cur_shape;
            idx = d2 * EXP_DEPTH / (2 * EXP_RANGE * sig * sig);
            lp = (idx < EXP_DEPTH) ? gauss_q16[idx] : 0;
            g = (cur_mode == MODE_GLP) ? lp : 65536 - lp;
        end
        f.re = apply_gain(re, g);
        f.im = apply_gain(im, g);
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filtered_t want;
        int        bad;
        if (!rst_n)
        begin
            cur_mode   <= MODE_PASS;
            cur_shape  <= '0;
            cur_width  <= DIM_W'(1024);
            cur_height <= DIM_W'(1024);
            errors     <= 0;
            pending    <= 0;
        end
        else
        begin
            bad = 0;
            if (done)
            begin
                if (filtered_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    bad++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (real_out !== want.re)
                    begin
                        $error("real_out expected %0d actual %0d",
                               $signed(want.re), real_out);
                        bad++;
                    end
                    if (imag_out !== want.im)
                    begin
                        $error("imag_out expected %0d actual %0d",
                               $signed(want.im), imag_out);
                        bad++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $error("saturated expected %0b actual %0b", want.sat, saturated);
                        bad++;
                    end
                end
            end
            if (start && !busy)
                filtered_q.push_back(filter_sample(row, col, real_in, imag_in));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODE:   cur_mode   <= cfg_data[MODE_W-1:0];
                    REG_SHAPE:  cur_shape  <= cfg_data;
                    REG_WIDTH:  cur_width  <= cfg_data;
                    REG_HEIGHT: cur_height <= cfg_data;
                    default:    ;
                endcase
            end
            if (bad != 0)
                errors <= errors + bad;
            pending <= filtered_q.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives the mask filter through a series of register settings covering
// every mode, cutoff and sigma extremes and odd, tiny and clamped spectrum
// sizes, with directed corner samples and random samples with random gaps.
// ---------------------------------------------------------------------------
module testbench;
    import fdm_pkg::*;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [POS_W-1:0]            row;
    logic [POS_W-1:0]            col;
    logic signed [SAMPLE_W-1:0]  real_in;
    logic signed [SAMPLE_W-1:0]  imag_in;
    logic                        done;
    logic signed [OUT_W-1:0]     real_out;
    logic signed [OUT_W-1:0]     imag_out;
    logic                        saturated;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    int                          errors;
    int                          pending;
    int                          sent;
    int                          max_gap;

    freq_domain_mask_filter_top uut (.*);

    mask_filter_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #3ms;
        $display("Verification failed");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_sample(int r, int c, logic [SAMPLE_W-1:0] re, logic [SAMPLE_W-1:0] im);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        @(negedge clk);
        start   = 1'b1;
        row     = POS_W'(r);
        col     = POS_W'(c);
        real_in = re;
        imag_in = im;
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    function automatic logic [SAMPLE_W-1:0] random_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom();
        endcase
    endfunction

    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic set_phase(int m, int shape, int w, int h);
        settle();
        write_reg(REG_MODE, m);
        write_reg(REG_SHAPE, shape);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    int phase_list[12][4] = '{
        '{MODE_PASS,  0,    1024, 1024},
        '{MODE_IDEAL, 0,    2,    2},
        '{MODE_IDEAL, 1024, 1024, 1024},
        '{MODE_IDEAL, 37,   640,  480},
        '{MODE_GLP,   0,    1024, 1024},
        '{MODE_GLP,   1024, 1024, 1024},
        '{MODE_GLP,   25,   333,  1023},
        '{MODE_GHP,   6,    128,  64},
        '{MODE_GHP,   2047, 0,    2047},
        '{MODE_LAP,   0,    1024, 1024},
        '{MODE_LAP,   3,    7,    1},
        '{7,          500,  1024, 1024}
    };

    initial
    begin
        start     = 1'b0;
        row       = '0;
        col       = '0;
        real_in   = '0;
        imag_in   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data  = '0;
        sent      = 0;
        max_gap   = 0;
        rst_n     = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings first: pass-through on a full-size spectrum.
        send_sample(0, 0, 32'h7fff_ffff, 32'h8000_0000);
        send_sample(512, 512, 32'h8000_0000, 32'h7fff_ffff);
        for (int m = MODE_PASS; m <= MODE_LAP; m++)
        begin
            set_phase(m, 3, 1024, 1024);
            send_sample(0, 0, 32'h7fff_ffff, 32'h8000_0000);
            send_sample(511, 513, 32'h8000_0000, 32'h7fff_ffff);
            send_sample(1023, 1023, 32'hffff_ffff, 32'h0000_0001);
            send_sample(2, 1, 32'h0000_0000, 32'h0000_8000);
            send_sample(512, 0, 32'h4000_0000, 32'hc000_0000);
        end

        foreach (phase_list[p])
        begin
            set_phase(phase_list[p][0], phase_list[p][1], phase_list[p][2], phase_list[p][3]);
            for (int i = 0; i < 104; i++)
            begin
                if (i % 26 == 0)
                    max_gap = ($urandom_range(0, 2) == 0) ? 0 : 7;
                if ($urandom_range(0, 3) == 0)
                    send_sample($urandom_range(0, 7), $urandom_range(1016, 1023),
                                random_value(), random_value());
                else
                    send_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                                random_value(), random_value());
            end
        end
        settle();

        $display("Sent %0d samples through %0d register settings and all five modes.",
                 sent, $size(phase_list) + 5);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== freq_domain_mask_filter_top.f =====
hdl/fdm_pkg.sv
hdl/fdm_offset.sv
hdl/fdm_gain.sv
hdl/fdm_scale.sv
hdl/freq_domain_mask_filter_top.sv
sim/mask_filter_checker.sv
sim/testbench.sv
